@@ hw/rtl/psm_pkg.sv @@
// Package for the polyphonic sawtooth mixer: sizes, register indexes,
// shared types and the octave step scaling function. No dependencies.
package psm_pkg;

  // Oscillator bank size and derived index widths.
  localparam int VOICES  = 16;
  localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VOICE_W = 4;
  localparam int VEXT_W  = (VIDX_W > VOICE_W) ? VIDX_W : VOICE_W;

  // Field and state widths.
  localparam int STEP_W   = 31;
  localparam int ACC_W    = 32;
  localparam int TOP_W    = 8;
  localparam int SUM_W    = 12;
  localparam int OCTAVE_W = 4;
  localparam int VOLUME_W = 5;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  // Reset values and the reference points of the two knobs.
  localparam logic [OCTAVE_W-1:0] OCTAVE_RST = OCTAVE_W'(4);
  localparam logic [VOLUME_W-1:0] VOLUME_RST = VOLUME_W'(16);
  localparam logic [OCTAVE_W-1:0] OCTAVE_MID = OCTAVE_W'(4);
  localparam logic [VOLUME_W-1:0] VOLUME_MAX = VOLUME_W'(16);
  localparam logic [3:0]          SHIFT_MAX  = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 1'b1;

  // One accumulator update travelling from the top level to the voice bank.
  typedef struct packed {
    logic              en;
    logic [VIDX_W-1:0] vidx;
    logic [ACC_W-1:0]  step;
  } note_upd_t;

  // Scale a base step by the octave: left above the middle octave,
  // right at or below it. Bits above the accumulator width are dropped.
  function automatic logic [ACC_W-1:0] scale_step(input logic [STEP_W-1:0]   step,
                                                  input logic [OCTAVE_W-1:0] octave);
    logic [ACC_W-1:0] base;
    logic [OCTAVE_W-1:0] amt;
    base = {{(ACC_W-STEP_W){1'b0}}, step};
    if (octave > OCTAVE_MID) begin
      amt = octave - OCTAVE_MID;
      scale_step = base << amt;
    end else begin
      amt = OCTAVE_MID - octave;
      scale_step = base >> amt;
    end
  endfunction

endpackage

@@ hw/rtl/psm_voice_bank.sv @@
// Bank of per-voice 32-bit phase accumulators with in-place update.
// Depends on psm_pkg for sizes and the note_upd_t type.
module psm_voice_bank
  import psm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  note_upd_t               upd,
  output logic signed [TOP_W-1:0] top
);

  logic [ACC_W-1:0] acc_r [VOICES];
  logic [ACC_W-1:0] acc_sum;

  // New phase of the addressed voice; its top byte is the sawtooth value.
  assign acc_sum = acc_r[upd.vidx] + upd.step;
  assign top     = signed'(acc_sum[ACC_W-1 -: TOP_W]);

  // Write the new phase back; reset clears every accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        acc_r[i] <= '0;
      end
    end else if (upd.en) begin
      acc_r[upd.vidx] <= acc_sum;
    end
  end

endmodule

@@ hw/rtl/psm_mixer.sv @@
// Running saturating sum of sawtooth values, volume shift and output register.
// Depends on psm_pkg for widths and knob constants.
module psm_mixer
  import psm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic                       note_en,
  input  logic                       emit,
  input  logic signed [TOP_W-1:0]    top,
  input  logic [VOLUME_W-1:0]        volume,
  output logic                       out_free,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SUM_W-1:0]    out_sample
);

  localparam logic signed [SUM_W:0] SAT_HI = (SUM_W+1)'((1 << (SUM_W-1)) - 1);
  localparam logic signed [SUM_W:0] SAT_LO = -(SUM_W+1)'(1 << (SUM_W-1));

  logic signed [SUM_W-1:0] sum_r, sum_nxt, sum_upd;
  logic signed [SUM_W:0]   sum_wide;
  logic [VOLUME_W-1:0]     vol_c;
  logic [3:0]              shift;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] out_sample_r;

  assign out_free = !out_valid_r || !out_stall;

  // Add the voice's top byte with saturation to the 12-bit range.
  always_comb begin
    sum_wide = {sum_r[SUM_W-1], sum_r} + (SUM_W+1)'(top);
    if (sum_wide > SAT_HI) begin
      sum_upd = SAT_HI[SUM_W-1:0];
    end else if (sum_wide < SAT_LO) begin
      sum_upd = SAT_LO[SUM_W-1:0];
    end else begin
      sum_upd = sum_wide[SUM_W-1:0];
    end
  end

  // Volume picks the arithmetic right shift; values above the top act as the top.
  always_comb begin
    vol_c = (volume > VOLUME_MAX) ? VOLUME_MAX : volume;
    shift = SHIFT_MAX - vol_c[VOLUME_W-1:1];
  end

  // Next sum and output word.
  always_comb begin
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (go) begin
      if (note_en) begin
        sum_nxt = sum_upd;
      end
      if (emit) begin
        sum_nxt       = '0;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The sample payload loads only when a frame ends.
  always_ff @(posedge clk) begin
    if (go && emit) begin
      out_sample_r <= (note_en ? sum_upd : sum_r) >>> shift;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

@@ hw/rtl/polyphonic_sawtooth_mixer_core.sv @@
// Top level of the polyphonic sawtooth mixer: input register, config registers,
// flow control; uses psm_pkg, psm_voice_bank and psm_mixer.
//
//   Channel  Ports                                          Moves
//   in       in_valid/in_stall, has_note, voice, step, last one note word
//   out      out_valid/out_stall, out_sample                one sample word
//   cfg      cfg_we, cfg_index, cfg_data                    octave or volume
//
// One word is taken per cycle while in_stall is low; an accepted word is held
// in the input register, which feeds the voice bank, and a frame's sample is
// registered on out. The rate is set by the accumulator read-add-write path.
// Reset is synchronous: accumulators and the sum clear, octave is 4, volume 16.
// A held output only stalls the input when a frame-ending word is waiting.
module polyphonic_sawtooth_mixer_core
  import psm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_has_note,
  input  logic [VOICE_W-1:0]      in_voice,
  input  logic [STEP_W-1:0]       in_note_step,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SUM_W-1:0] out_sample,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  logic [OCTAVE_W-1:0] octave_r;
  logic [VOLUME_W-1:0] volume_r;

  logic                s1_valid_r;
  logic                s1_has_note_r;
  logic [VOICE_W-1:0]  s1_voice_r;
  logic [STEP_W-1:0]   s1_step_r;
  logic                s1_last_r;

  logic [VEXT_W-1:0]      voice_ext;
  logic                   in_range;
  logic                   emit;
  logic                   go;
  logic                   out_free;
  note_upd_t              upd;
  logic signed [TOP_W-1:0] top;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_r <= OCTAVE_RST;
      volume_r <= VOLUME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OCTAVE: octave_r <= cfg_data[OCTAVE_W-1:0];
        CFG_VOLUME: volume_r <= cfg_data[VOLUME_W-1:0];
        default:    ;
      endcase
    end
  end

  // Stage control: a word that ends a frame needs room in the output register.
  assign emit     = !s1_has_note_r || s1_last_r;
  assign go       = s1_valid_r && (!emit || out_free);
  assign in_stall = s1_valid_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_has_note_r <= in_has_note;
      s1_voice_r    <= in_voice;
      s1_step_r     <= in_note_step;
      s1_last_r     <= in_last;
    end
  end

  // Accumulator update for a note whose voice exists in the bank.
  assign voice_ext = VEXT_W'(s1_voice_r);
  assign in_range  = int'(voice_ext) < VOICES;
  assign upd.en    = go && s1_has_note_r && in_range;
  assign upd.vidx  = voice_ext[VIDX_W-1:0];
  assign upd.step  = scale_step(s1_step_r, octave_r);

  psm_voice_bank u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .top   (top)
  );

  psm_mixer u_mixer (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .note_en    (upd.en),
    .emit       (emit),
    .top        (top),
    .volume     (volume_r),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample)
  );

endmodule
